// ===== hdl/pwb_pkg.sv =====
// pwb_pkg: shared types, constants and helpers of the percentile white balance block.
// No dependencies.
package pwb_pkg;

  localparam int PIXEL_COUNT_BITS = 20;
  localparam int CNT_W  = PIXEL_COUNT_BITS + 1;     // saturating counter width
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int ACC_W  = CNT_W + 6;                // signed running count
  localparam int PRD_W  = ACC_W + 7;                // 100 * running count
  localparam int THR_W  = CNT_W + 7;                // percent * total
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FINE_BINS   = 256;
  localparam int COARSE_BINS = 16;
  localparam int NUM_CH      = 3;
  localparam logic [5:0] CLIP_MAX = 6'd49;
  localparam logic [1:0] CFG_WHITE_LEVEL = 2'd0;
  localparam logic [1:0] CFG_LOW_CLIP    = 2'd1;
  localparam logic [1:0] CFG_HIGH_CLIP   = 2'd2;

  typedef struct packed {
    logic                    apply;   // 1: apply pass, 0: histogram pass
    logic [NUM_CH-1:0][7:0]  px;      // 0 blue, 1 green, 2 red
    logic                    last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  typedef struct packed {
    logic [15:0] white_level;
    logic [5:0]  low_clip;
    logic [5:0]  high_clip;
  } cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

// ===== hdl/pwb_ram.sv =====
// pwb_ram: generic single write port RAM with one registered read port.
// No dependencies.
module pwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/pwb_front.sv =====
// pwb_front: input beat acceptance, pass classification and a short item queue.
// Depends on pwb_pkg.
module pwb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_kind,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_red,
  input  logic               in_last,
  input  pwb_pkg::back_stat_t stat,
  input  logic               head_pop,
  output pwb_pkg::head_t     head
);
  pwb_pkg::item_t               q_r [pwb_pkg::FIFO_DEPTH];
  logic [pwb_pkg::FIFO_AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [pwb_pkg::FIFO_AW:0]    cnt_r, cnt_nxt;
  pwb_pkg::item_t               new_item;
  logic                         acc, pop;

  assign in_full = (cnt_r == (pwb_pkg::FIFO_AW+1)'(pwb_pkg::FIFO_DEPTH)) | stat.init_busy;
  assign acc     = in_push & ~in_full;
  assign pop     = head_pop & (cnt_r != '0);

  always_comb begin
    new_item.apply = in_kind;
    new_item.px    = {in_red, in_green, in_blue};
    new_item.last  = in_last;
    wp_nxt  = acc ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (pwb_pkg::FIFO_AW+1)'(acc) - (pwb_pkg::FIFO_AW+1)'(pop);
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (acc) begin
      q_r[wp_r] <= new_item;
    end
  end
endmodule

// ===== hdl/pwb_back.sv =====
// pwb_back: histogram update, per-channel cut search, clearing sweep and pixel mapping.
// Depends on pwb_pkg and pwb_ram.
module pwb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pwb_pkg::cfg_t       cfg,
  input  pwb_pkg::head_t      head,
  output logic                head_pop,
  output pwb_pkg::back_stat_t stat,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [7:0]          out_blue,
  output logic [7:0]          out_green,
  output logic [7:0]          out_red,
  output logic                out_last
);
  localparam int CW = pwb_pkg::CNT_W;
  localparam int AW = pwb_pkg::ACC_W;
  localparam int PW = pwb_pkg::PRD_W;
  localparam int TW = pwb_pkg::THR_W;
  localparam int NC = pwb_pkg::NUM_CH;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_H_RD   = 17'h00002,
    S_H_WR   = 17'h00004,
    S_INIT   = 17'h00008,
    S_LC_RD  = 17'h00010,
    S_LC_EV  = 17'h00020,
    S_LF_RD  = 17'h00040,
    S_LF_EV  = 17'h00080,
    S_UC_RD  = 17'h00100,
    S_UC_EV  = 17'h00200,
    S_UF_RD  = 17'h00400,
    S_UF_EV  = 17'h00800,
    S_CLR    = 17'h01000,
    S_A_MUL  = 17'h02000,
    S_A_SAT  = 17'h04000,
    S_A_DIV  = 17'h08000,
    S_A_OUT  = 17'h10000
  } state_t;

  state_t                 state_r, state_nxt;
  pwb_pkg::item_t         item_r, item_nxt;
  logic [1:0]             ch_r, ch_nxt;
  logic [7:0]             p_r, p_nxt;
  logic signed [AW-1:0]   n_r, n_nxt;
  logic [TW-1:0]          lo_thr_r, lo_thr_nxt, hi_thr_r, hi_thr_nxt;
  logic [CW-1:0]          total_r, total_nxt;
  logic [7:0]             clr_r, clr_nxt;
  logic                   init_r, init_nxt;
  logic [NC-1:0][7:0]     low_cut_r, low_cut_nxt, high_cut_r, high_cut_nxt;

  // mapping lanes
  logic [NC-1:0][16:0]    rem_r, rem_nxt;
  logic [NC-1:0][8:0]     rng_r, rng_nxt;
  logic [NC-1:0]          zero_r, zero_nxt, sat_r, sat_nxt;
  logic [NC-1:0][7:0]     q_r, q_nxt;
  logic [2:0]             k_r, k_nxt;

  logic                   ov_r, ov_nxt;
  logic [NC-1:0][7:0]     ob_r, ob_nxt;
  logic                   ol_r, ol_nxt;

  // histogram RAMs
  logic                   we;
  logic [NC-1:0][7:0]     f_waddr, f_raddr;
  logic [NC-1:0][3:0]     c_waddr, c_raddr;
  logic [NC-1:0][CW-1:0]  f_wdata, c_wdata, f_q, c_q;

  logic                   search;
  logic [CW-1:0]          cnt_sel;
  logic signed [AW-1:0]   acc_add, acc_sub;
  logic signed [PW-1:0]   prd_add, prd_sub, lo_s, hi_s;
  logic                   go_lo, go_hi;
  logic [5:0]             s1, s2;

  for (genvar c = 0; c < NC; c++) begin : g_ram
    pwb_ram #(.WIDTH(CW), .DEPTH(pwb_pkg::FINE_BINS)) u_fine (
      .clk(clk), .we(we), .waddr(f_waddr[c]), .wdata(f_wdata[c]),
      .raddr(f_raddr[c]), .rdata(f_q[c]));
    pwb_ram #(.WIDTH(CW), .DEPTH(pwb_pkg::COARSE_BINS)) u_coarse (
      .clk(clk), .we(we), .waddr(c_waddr[c]), .wdata(c_wdata[c]),
      .raddr(c_raddr[c]), .rdata(c_q[c]));
  end

  assign search = (state_r != S_IDLE) && (state_r != S_H_RD) && (state_r != S_H_WR);

  always_comb begin
    we = (state_r == S_H_WR) || (state_r == S_CLR);
    for (int c = 0; c < NC; c++) begin
      f_raddr[c] = search ? p_r : item_r.px[c];
      c_raddr[c] = search ? p_r[3:0] : item_r.px[c][7:4];
      f_waddr[c] = (state_r == S_CLR) ? clr_r : item_r.px[c];
      c_waddr[c] = (state_r == S_CLR) ? clr_r[3:0] : item_r.px[c][7:4];
      f_wdata[c] = (state_r == S_CLR) ? '0 : pwb_pkg::sat_inc(f_q[c]);
      c_wdata[c] = (state_r == S_CLR) ? '0 : pwb_pkg::sat_inc(c_q[c]);
    end
  end

  // search compare: 100 * (n +/- count) against percent * total
  always_comb begin
    cnt_sel = ((state_r == S_LC_EV) || (state_r == S_UC_EV)) ? c_q[ch_r] : f_q[ch_r];
    acc_add = n_r + $signed({{(AW-CW){1'b0}}, cnt_sel});
    acc_sub = n_r - $signed({{(AW-CW){1'b0}}, cnt_sel});
    prd_add = {{(PW-AW){acc_add[AW-1]}}, acc_add} * $signed(PW'(100));
    prd_sub = {{(PW-AW){acc_sub[AW-1]}}, acc_sub} * $signed(PW'(100));
    lo_s    = $signed({{(PW-TW){1'b0}}, lo_thr_r});
    hi_s    = $signed({{(PW-TW){1'b0}}, hi_thr_r});
    go_lo   = prd_add < lo_s;
    go_hi   = prd_sub > hi_s;
    s1 = (cfg.low_clip  > pwb_pkg::CLIP_MAX) ? pwb_pkg::CLIP_MAX : cfg.low_clip;
    s2 = (cfg.high_clip > pwb_pkg::CLIP_MAX) ? pwb_pkg::CLIP_MAX : cfg.high_clip;
  end

  always_comb begin
    logic signed [8:0]  d;
    logic signed [9:0]  rs;
    logic signed [26:0] num;
    logic [25:0]        nsum;
    logic [16:0]        trial;

    state_nxt    = state_r;
    item_nxt     = item_r;
    ch_nxt       = ch_r;
    p_nxt        = p_r;
    n_nxt        = n_r;
    lo_thr_nxt   = lo_thr_r;
    hi_thr_nxt   = hi_thr_r;
    total_nxt    = total_r;
    clr_nxt      = clr_r;
    init_nxt     = init_r;
    low_cut_nxt  = low_cut_r;
    high_cut_nxt = high_cut_r;
    rem_nxt      = rem_r;
    rng_nxt      = rng_r;
    zero_nxt     = zero_r;
    sat_nxt      = sat_r;
    q_nxt        = q_r;
    k_nxt        = k_r;
    ov_nxt       = ov_r & ~out_pop;
    ob_nxt       = ob_r;
    ol_nxt       = ol_r;
    head_pop     = 1'b0;
    d = '0; rs = '0; num = '0; nsum = '0; trial = '0;

    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          head_pop  = 1'b1;
          item_nxt  = head.item;
          state_nxt = head.item.apply ? S_A_MUL : S_H_RD;
        end
      end
      S_H_RD: state_nxt = S_H_WR;
      S_H_WR: begin
        total_nxt = pwb_pkg::sat_inc(total_r);
        ch_nxt    = 2'd0;
        state_nxt = item_r.last ? S_INIT : S_IDLE;
      end
      S_INIT: begin
        lo_thr_nxt = TW'(s1) * total_r;
        hi_thr_nxt = TW'(7'd100 - {1'b0, s2}) * total_r;
        p_nxt      = '0;
        n_nxt      = '0;
        state_nxt  = S_LC_RD;
      end
      S_LC_RD: begin
        if (p_r[3:0] == 4'hF) begin
          p_nxt     = {p_r[3:0], 4'h0};
          state_nxt = S_LF_RD;
        end else begin
          state_nxt = S_LC_EV;
        end
      end
      S_LC_EV: begin
        if (go_lo) begin
          n_nxt     = acc_add;
          p_nxt     = p_r + 8'd1;
          state_nxt = S_LC_RD;
        end else begin
          p_nxt     = {p_r[3:0], 4'h0};
          state_nxt = S_LF_RD;
        end
      end
      S_LF_RD, S_LF_EV: begin
        if (state_r == S_LF_EV && go_lo) begin
          n_nxt     = acc_add;
          p_nxt     = p_r + 8'd1;
          state_nxt = S_LF_RD;
        end else if (state_r == S_LF_RD && p_r[3:0] != 4'hF) begin
          state_nxt = S_LF_EV;
        end else begin
          low_cut_nxt[ch_r] = p_r;
          n_nxt     = $signed({{(AW-CW){1'b0}}, total_r});
          p_nxt     = 8'd15;
          state_nxt = S_UC_RD;
        end
      end
      S_UC_RD: begin
        if (p_r[3:0] == 4'h0) begin
          p_nxt     = {p_r[3:0], 4'hF};
          state_nxt = S_UF_RD;
        end else begin
          state_nxt = S_UC_EV;
        end
      end
      S_UC_EV: begin
        if (go_hi) begin
          n_nxt     = acc_sub;
          p_nxt     = p_r - 8'd1;
          state_nxt = S_UC_RD;
        end else begin
          p_nxt     = {p_r[3:0], 4'hF};
          state_nxt = S_UF_RD;
        end
      end
      S_UF_RD, S_UF_EV: begin
        if (state_r == S_UF_EV && go_hi) begin
          n_nxt     = acc_sub;
          p_nxt     = p_r - 8'd1;
          state_nxt = S_UF_RD;
        end else if (state_r == S_UF_RD && p_r[3:0] != 4'h0) begin
          state_nxt = S_UF_EV;
        end else begin
          high_cut_nxt[ch_r] = p_r;
          if (ch_r == 2'(NC - 1)) begin
            total_nxt = '0;
            clr_nxt   = '0;
            state_nxt = S_CLR;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            p_nxt     = '0;
            n_nxt     = '0;
            state_nxt = S_LC_RD;
          end
        end
      end
      S_CLR: begin
        clr_nxt = clr_r + 8'd1;
        if (clr_r == 8'(pwb_pkg::FINE_BINS - 1)) begin
          init_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_A_MUL: begin
        for (int c = 0; c < NC; c++) begin
          d   = $signed({1'b0, item_r.px[c]}) - $signed({1'b0, low_cut_r[c]});
          num = $signed({11'b0, cfg.white_level}) * $signed({{17{d[8]}}, d, 1'b1});
          rs  = $signed({2'b0, high_cut_r[c]}) - $signed({2'b0, low_cut_r[c]}) + 10'sd1;
          rng_nxt[c]  = (rs < 10'sd1) ? 9'd1 : rs[8:0];
          zero_nxt[c] = (num <= 27'sd0);
          nsum        = num[25:0] + {9'b0, rng_nxt[c], 8'b0};
          rem_nxt[c]  = nsum[25:9];
        end
        state_nxt = S_A_SAT;
      end
      S_A_SAT: begin
        for (int c = 0; c < NC; c++) begin
          sat_nxt[c] = rem_r[c] >= {rng_r[c], 8'b0};
          q_nxt[c]   = '0;
        end
        k_nxt     = 3'd7;
        state_nxt = S_A_DIV;
      end
      S_A_DIV: begin
        for (int c = 0; c < NC; c++) begin
          trial = {8'b0, rng_r[c]} << k_r;
          if (rem_r[c] >= trial) begin
            rem_nxt[c]    = rem_r[c] - trial;
            q_nxt[c][k_r] = 1'b1;
          end
        end
        k_nxt = k_r - 3'd1;
        if (k_r == 3'd0) begin
          state_nxt = S_A_OUT;
        end
      end
      S_A_OUT: begin
        if (!ov_r || out_pop) begin
          for (int c = 0; c < NC; c++) begin
            ob_nxt[c] = zero_r[c] ? 8'd0 : (sat_r[c] ? 8'd255 : q_r[c]);
          end
          ol_nxt    = item_r.last;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      init_r     <= 1'b1;
      total_r    <= '0;
      ov_r       <= 1'b0;
      ch_r       <= '0;
      low_cut_r  <= '0;
      high_cut_r <= {NC{8'd255}};
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      init_r     <= init_nxt;
      total_r    <= total_nxt;
      ov_r       <= ov_nxt;
      ch_r       <= ch_nxt;
      low_cut_r  <= low_cut_nxt;
      high_cut_r <= high_cut_nxt;
    end
    item_r   <= item_nxt;
    p_r      <= p_nxt;
    n_r      <= n_nxt;
    lo_thr_r <= lo_thr_nxt;
    hi_thr_r <= hi_thr_nxt;
    rem_r    <= rem_nxt;
    rng_r    <= rng_nxt;
    zero_r   <= zero_nxt;
    sat_r    <= sat_nxt;
    q_r      <= q_nxt;
    k_r      <= k_nxt;
    ob_r     <= ob_nxt;
    ol_r     <= ol_nxt;
  end

  assign stat.init_busy = init_r;
  assign out_empty = ~ov_r;
  assign out_blue  = ob_r[0];
  assign out_green = ob_r[1];
  assign out_red   = ob_r[2];
  assign out_last  = ol_r;
endmodule

// ===== hdl/percentile_white_balance_core.sv =====
// percentile_white_balance_core: top level, configuration registers and the
// front/back split. Depends on pwb_pkg, pwb_front, pwb_back (and pwb_ram below it).
//
//  channel  ports                                 beat
//  in       in_push/in_full, in_kind, in_* pixel  one pixel, either pass
//  out      out_pop/out_empty, out_* pixel        one balanced pixel
//  cfg      cfg_we, cfg_index, cfg_data           one register write
//
// Histogram beat: queue pop, RAM read and RAM write in the back end.
// Apply beat: pop, multiply, saturate check, 8 divide steps, output.
// Last histogram beat: adds the cut search for all three channels, a read and an
// evaluate state a bin step, then a clearing sweep over all 256 fine bins.
// After reset the same clearing sweep runs with in_full high.
// A 4-beat queue keeps in_push taking beats while the back end is busy or out_pop stalls.
module percentile_white_balance_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_kind,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  pwb_pkg::cfg_t       cfg_r, cfg_nxt;
  pwb_pkg::head_t      head;
  pwb_pkg::back_stat_t stat;
  logic                head_pop;

  // register writes; an index past the list is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pwb_pkg::CFG_WHITE_LEVEL: cfg_nxt.white_level = cfg_data;
        pwb_pkg::CFG_LOW_CLIP:    cfg_nxt.low_clip    = cfg_data[5:0];
        pwb_pkg::CFG_HIGH_CLIP:   cfg_nxt.high_clip   = cfg_data[5:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.white_level <= 16'd65280;  // 255.0 in 8.8
      cfg_r.low_clip    <= 6'd1;
      cfg_r.high_clip   <= 6'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pwb_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_kind(in_kind), .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .in_last(in_last),
    .stat(stat), .head_pop(head_pop), .head(head)
  );

  pwb_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .head(head), .head_pop(head_pop), .stat(stat),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
    .out_last(out_last)
  );
endmodule
